// ===== rtl/keypad_matrix_debounce_core_assert.svh =====
// Assertion macros for the keypad matrix debounce core.
// Needs a clock named clk and a synchronous active-high reset named rst in scope.
`ifndef KEYPAD_MATRIX_DEBOUNCE_CORE_ASSERT_SVH
`define KEYPAD_MATRIX_DEBOUNCE_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define KMD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define KMD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/kmd_pkg.sv =====
// Shared constants and the key position table for the keypad matrix debounce core.
// No dependencies.
package kmd_pkg;

  localparam int ROWS_DEFAULT   = 5;
  localparam int COLS_DEFAULT   = 6;
  localparam int MATRIX_W       = 30;
  localparam int CODE_W         = 5;
  localparam int TICKS_W        = 4;
  localparam int TABLE_ROWS     = 5;
  localparam int TABLE_COLS     = 6;

  localparam logic [CODE_W-1:0]  CODE_NONE      = 5'd0;
  localparam logic [CODE_W-1:0]  CODE_MULTI     = 5'd27;
  localparam logic [TICKS_W-1:0] DEBOUNCE_RESET = 4'd4;

  typedef logic [CODE_W-1:0] code_t;

  localparam code_t KEY_TABLE [TABLE_ROWS*TABLE_COLS] = '{
    5'd1,  5'd2,  5'd3,  5'd4,  5'd5,  5'd6,
    5'd7,  5'd8,  5'd9,  5'd10, 5'd11, 5'd12,
    5'd13, 5'd14, 5'd15, 5'd16, 5'd17, 5'd18,
    5'd0,  5'd0,  5'd19, 5'd20, 5'd21, 5'd22,
    5'd23, 5'd24, 5'd25, 5'd26, 5'd0,  5'd0
  };

  // Code of the key at (r, c); positions outside the table are unmapped.
  function automatic code_t key_at(input int r, input int c);
    code_t code;
    code = CODE_NONE;
    if (r < TABLE_ROWS && c < TABLE_COLS) begin
      code = KEY_TABLE[r*TABLE_COLS + c];
    end
    return code;
  endfunction

endpackage

// ===== rtl/keypad_matrix_debounce_core.sv =====
// Keypad matrix debounce core: each input beat passes the decode register, then the result register.
// Throughput one beat per cycle; a stalled result only blocks once both the
// decode register and the result register are full.
// Synchronous active-high reset: debounce_ticks 4, candidate 0, count 0,
// armed set, accepted key 0, both pipeline registers empty.
// Depends on kmd_pkg and keypad_matrix_debounce_core_assert.svh.
`include "keypad_matrix_debounce_core_assert.svh"

module keypad_matrix_debounce_core #(
  parameter int ROWS = kmd_pkg::ROWS_DEFAULT,
  parameter int COLS = kmd_pkg::COLS_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [kmd_pkg::TICKS_W-1:0] cfg_data,   // debounce_ticks
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [31:0]                 s_tdata,    // [29:0] pressed_matrix
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [15:0]                 m_tdata,    // [4:0] key_code, [9:5] raw_code
  output logic                        m_tuser     // key_event
);
  import kmd_pkg::*;

  localparam int NPOS = (ROWS*COLS < MATRIX_W) ? ROWS*COLS : MATRIX_W;

  logic [TICKS_W-1:0] debounce_ticks;
  logic               s1_valid;
  code_t              raw_q;
  logic               o_valid;
  code_t              o_key;
  code_t              o_raw;
  logic               o_event;

  code_t              candidate_code, candidate_code_next;
  logic [TICKS_W-1:0] stable_ticks, stable_ticks_next;
  logic               armed, armed_next;
  code_t              accepted_key, accepted_key_next;
  logic               event_next;

  logic [MATRIX_W-1:0] live;
  code_t               code_or;
  code_t               raw_next;
  logic                advance_out;
  logic                load_out;
  logic                in_fire;

  assign cfg_ready   = 1'b1;
  assign advance_out = !o_valid || m_tready;
  assign load_out    = s1_valid && advance_out;
  assign s_tready    = !s1_valid || advance_out;
  assign in_fire     = s_tvalid && s_tready;

  // Decode: mask to scanned positions; no key -> NONE, several or unmapped -> MULTI, else its code.
  always_comb begin
    live    = '0;
    code_or = CODE_NONE;
    for (int r = 0; r < ROWS; r++) begin
      for (int c = 0; c < COLS; c++) begin
        if (r*COLS + c < NPOS) begin
          live[r*COLS + c] = s_tdata[r*COLS + c];
          if (s_tdata[r*COLS + c]) begin
            code_or = code_or | key_at(r, c);
          end
        end
      end
    end
    if (live == '0) begin
      raw_next = CODE_NONE;
    end else if ((live & (live - MATRIX_W'(1))) != '0 || code_or == CODE_NONE) begin
      raw_next = CODE_MULTI;
    end else begin
      raw_next = code_or;
    end
  end

  // Debounce update for the beat leaving the decode register.
  always_comb begin
    candidate_code_next = candidate_code;
    stable_ticks_next   = stable_ticks;
    armed_next          = armed;
    accepted_key_next   = accepted_key;
    event_next          = 1'b0;
    if (raw_q != candidate_code) begin
      candidate_code_next = raw_q;
      stable_ticks_next   = TICKS_W'(1);
    end else begin
      if (stable_ticks < debounce_ticks) begin
        stable_ticks_next = stable_ticks + TICKS_W'(1);
      end
      if (stable_ticks_next >= debounce_ticks) begin
        if (candidate_code == CODE_NONE) begin
          armed_next = 1'b1;
        end else if (candidate_code != CODE_MULTI && armed) begin
          accepted_key_next = candidate_code;
          armed_next        = 1'b0;
          event_next        = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks <= DEBOUNCE_RESET;
      s1_valid       <= 1'b0;
      o_valid        <= 1'b0;
      candidate_code <= CODE_NONE;
      stable_ticks   <= '0;
      armed          <= 1'b1;
      accepted_key   <= CODE_NONE;
    end else begin
      if (cfg_valid && cfg_ready) begin
        debounce_ticks <= cfg_data;
      end
      if (in_fire) begin
        s1_valid <= 1'b1;
      end else if (load_out) begin
        s1_valid <= 1'b0;
      end
      if (load_out) begin
        o_valid        <= 1'b1;
        candidate_code <= candidate_code_next;
        stable_ticks   <= stable_ticks_next;
        armed          <= armed_next;
        accepted_key   <= accepted_key_next;
      end else if (m_tready) begin
        o_valid <= 1'b0;
      end
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      raw_q <= raw_next;
    end
    if (load_out) begin
      o_key   <= accepted_key_next;
      o_raw   <= raw_q;
      o_event <= event_next;
    end
  end

  assign m_tvalid = o_valid;
  assign m_tdata  = {6'd0, o_raw, o_key};
  assign m_tuser  = o_event;

  `KMD_ASSERT_NOW(a_event_matches_raw, o_valid && o_event,
    o_key == o_raw && o_raw != CODE_NONE && o_raw != CODE_MULTI,
    "key event with a code that differs from the raw code")
  `KMD_ASSERT_NEXT(a_event_disarms, load_out && event_next, !armed,
    "block still armed after a key was latched")
  `KMD_ASSERT_NOW(a_raw_in_range, s1_valid, raw_q <= CODE_MULTI,
    "decoded raw code out of range")

endmodule

// ===== test/keypad_matrix_debounce_core_tb.sv =====
// Testbench for keypad_matrix_debounce_core: drives scan beats and debounce settings,
// predicts each result beat from its own debounce model and checks every field.
// Depends on kmd_pkg and the core RTL.
module keypad_matrix_debounce_core_tb;

  import kmd_pkg::*;

  localparam int SCAN_BITS = 30;
  localparam int IDLE_PCT  = 24;

  // Key code per matrix position, row-major; zero marks an unmapped position.
  localparam code_t KEYMAP [SCAN_BITS] = '{
    5'd1,  5'd2,  5'd3,  5'd4,  5'd5,  5'd6,
    5'd7,  5'd8,  5'd9,  5'd10, 5'd11, 5'd12,
    5'd13, 5'd14, 5'd15, 5'd16, 5'd17, 5'd18,
    5'd0,  5'd0,  5'd19, 5'd20, 5'd21, 5'd22,
    5'd23, 5'd24, 5'd25, 5'd26, 5'd0,  5'd0
  };

  typedef struct packed {
    code_t key_code;
    logic  key_event;
    code_t raw_code;
  } scan_result_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [TICKS_W-1:0]  cfg_data = '0;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [31:0]         s_tdata = '0;    // [29:0] pressed_matrix
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [15:0]         m_tdata;         // [4:0] key_code, [9:5] raw_code
  logic                m_tuser;         // key_event

  // debounce model state
  logic [TICKS_W-1:0]  debounce_ticks = DEBOUNCE_RESET;
  code_t               candidate = CODE_NONE;
  logic [TICKS_W-1:0]  stable_count = '0;
  logic                armed = 1'b1;
  code_t               accepted_key = CODE_NONE;

  scan_result_t        scan_results_q[$];
  scan_result_t        got_result;
  scan_result_t        want_result;
  int                  mismatches = 0;
  int                  scans_sent = 0;
  bit                  steady_flow = 1'b0;

  keypad_matrix_debounce_core dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #5 clk = ~clk;

  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic code_t scan_code(input logic [SCAN_BITS-1:0] matrix);
    code_t code;
    code = CODE_NONE;
    if ($countones(matrix) > 1) begin
      code = CODE_MULTI;
    end else begin
      for (int p = 0; p < SCAN_BITS; p++) begin
        if (matrix[p]) begin
          code = (KEYMAP[p] == CODE_NONE) ? CODE_MULTI : KEYMAP[p];
        end
      end
    end
    return code;
  endfunction

  // Advance the debounce model by one scan tick and queue the result it yields.
  function automatic void debounce_tick(input logic [SCAN_BITS-1:0] matrix);
    code_t        raw;
    scan_result_t res;
    raw = scan_code(matrix);
    res.key_event = 1'b0;
    if (raw != candidate) begin
      candidate = raw;
      stable_count = 4'd1;
    end else begin
      if (stable_count < debounce_ticks) begin
        stable_count = stable_count + 4'd1;
      end
      if (stable_count >= debounce_ticks) begin
        if (candidate == CODE_NONE) begin
          armed = 1'b1;
        end else if (candidate != CODE_MULTI && armed) begin
          accepted_key = candidate;
          armed = 1'b0;
          res.key_event = 1'b1;
        end
      end
    end
    res.key_code = accepted_key;
    res.raw_code = raw;
    scan_results_q.push_back(res);
  endfunction

  function automatic void report_mismatch(input string what, input scan_result_t want,
                                          input scan_result_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%s: want key=%0d ev=%0d raw=%0d, got key=%0d ev=%0d raw=%0d",
               what, want.key_code, want.key_event, want.raw_code,
               got.key_code, got.key_event, got.raw_code);
    end
  endfunction

  // result side: check each accepted beat, stall at random unless steady_flow is set
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got_result.key_code  = m_tdata[4:0];
      got_result.raw_code  = m_tdata[9:5];
      got_result.key_event = m_tuser;
      if (scan_results_q.size() == 0) begin
        report_mismatch("unexpected result beat", '0, got_result);
      end else begin
        want_result = scan_results_q.pop_front();
        if (got_result !== want_result) begin
          report_mismatch("result mismatch", want_result, got_result);
        end
      end
    end
    m_tready <= steady_flow || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  task automatic send_scan(input logic [SCAN_BITS-1:0] matrix);
    if (!steady_flow && $urandom_range(0, 99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
      while (!steady_flow && $urandom_range(0, 99) < IDLE_PCT) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {2'b00, matrix};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    debounce_tick(matrix);
    scans_sent++;
  endtask

  task automatic hold_scan(input logic [SCAN_BITS-1:0] matrix, input int ticks);
    repeat (ticks) send_scan(matrix);
  endtask

  // Hold off input until every queued result has come back.
  task automatic drain_results;
    s_tvalid <= 1'b0;
    do @(posedge clk); while (scan_results_q.size() != 0);
  endtask

  task automatic write_debounce(input logic [TICKS_W-1:0] ticks);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= ticks;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    debounce_ticks = ticks;
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [SCAN_BITS-1:0] random_key(input bit mapped);
    int p;
    do p = $urandom_range(0, SCAN_BITS - 1); while ((KEYMAP[p] != CODE_NONE) != mapped);
    return 30'd1 << p;
  endfunction

  function automatic int random_hold;
    return $urandom_range(1, int'(debounce_ticks) + 3);
  endfunction

  task automatic test_reset_press;
    hold_scan('0, 2);
    hold_scan(30'd1, 4);
    hold_scan('0, 3);
  endtask

  task automatic test_matrix_extremes;
    write_debounce(4'd1);
    hold_scan({SCAN_BITS{1'b1}}, 2);
    hold_scan(30'd1 << 29, 2);
    send_scan(30'd1 << 18);
    hold_scan('0, 2);
    hold_scan(30'd1 << 27, 2);
    send_scan(30'd1 | (30'd1 << 27));
  endtask

  task automatic test_zero_debounce;
    write_debounce(4'd0);
    hold_scan(30'd1 << 23, 2);
    hold_scan('0, 2);
    send_scan(30'd1 << 23);
  endtask

  task automatic test_lowered_debounce;
    write_debounce(4'd15);
    hold_scan('0, 2);
    hold_scan(30'd1 << 14, 5);
    write_debounce(4'd2);
    send_scan(30'd1 << 14);
  endtask

  task automatic press_sequence;
    logic [SCAN_BITS-1:0] key;
    int                   hold;
    int                   kind;
    kind = $urandom_range(0, 9);
    if (kind <= 6) begin
      key  = random_key(1'b1);
      hold = random_hold();
      for (int i = 0; i < hold; i++) begin
        // inject a one-tick contact bounce now and then
        if ($urandom_range(0, 9) == 0) begin
          send_scan($urandom_range(0, 1) ? '0 : (key | random_key(1'b1)));
        end
        send_scan(key);
      end
      hold_scan('0, random_hold());
    end else if (kind == 7) begin
      repeat ($urandom_range(1, 3)) send_scan(SCAN_BITS'($urandom));
    end else if (kind == 8) begin
      hold_scan(random_key(1'b0), random_hold());
    end else begin
      hold_scan(random_key(1'b1) | random_key(1'b1), random_hold());
    end
  endtask

  task automatic scan_phase(input logic [TICKS_W-1:0] ticks, input int count);
    int goal;
    write_debounce(ticks);
    goal = scans_sent + count;
    while (scans_sent < goal) begin
      press_sequence();
      if ($urandom_range(0, 39) == 0) begin
        drain_results();
      end
    end
  endtask

  task automatic test_random_scans;
    scan_phase(4'd1, 225);
    scan_phase(4'd15, 225);
    scan_phase(4'd0, 225);
    scan_phase(4'd3, 225);
    scan_phase(4'($urandom_range(1, 15)), 225);
    steady_flow = 1'b1;
    scan_phase(DEBOUNCE_RESET, 225);
    steady_flow = 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_reset_press();
    test_matrix_extremes();
    test_zero_debounce();
    test_lowered_debounce();
    test_random_scans();
    drain_results();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && scan_results_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/kmd_pkg.sv
rtl/keypad_matrix_debounce_core.sv
test/keypad_matrix_debounce_core_tb.sv
